### rtl/cmbenum_pkg.sv
// Package for the combination enumerator: field widths, register map,
// reset values and the control state type. No dependencies.
`timescale 1ns / 1ps

package cmbenum_pkg;

  localparam int unsigned SET_W  = 7;   // set_size register
  localparam int unsigned SUB_W  = 5;   // subset_size register
  localparam int unsigned POS_W  = 4;   // position field
  localparam int unsigned ELEM_W = 6;   // element value field
  localparam int unsigned DATA_W = 32;  // configuration data bus
  localparam int unsigned ADDR_W = 3;   // two word registers

  localparam logic [SET_W-1:0] SET_SIZE_RST = SET_W'(8);
  localparam logic [SUB_W-1:0] SUB_SIZE_RST = SUB_W'(3);

  typedef enum logic {
    REG_SET_SIZE = 1'b0,
    REG_SUB_SIZE = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_INV
  } state_t;

endpackage

### rtl/cmbenum_in_if.sv
// Input channel of the combination enumerator: one restart flag per item.
// Uses nothing from cmbenum_pkg.
`timescale 1ns / 1ps

interface cmbenum_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

### rtl/cmbenum_out_if.sv
// Result channel of the combination enumerator: one element per item.
// Depends on cmbenum_pkg for field widths.
`timescale 1ns / 1ps

interface cmbenum_out_if;
  logic                             valid;
  logic                             ready;
  logic [cmbenum_pkg::POS_W-1:0]    position;
  logic [cmbenum_pkg::ELEM_W-1:0]   element_value;
  logic                             last_element;
  logic                             wrapped;
  logic                             invalid;

  modport source (output valid, output position, output element_value,
                  output last_element, output wrapped, output invalid,
                  input ready);
  modport sink   (input valid, input position, input element_value,
                  input last_element, input wrapped, input invalid,
                  output ready);
endinterface

### rtl/combination_enumerator.sv
// Lexicographic k-combination successor. Restart: emits the first combination.
// Advance: scans right to left, one memory read per cycle (registered read), for
// the position p that grows, then emits k elements, refilling from p on; wraps
// if none grows. One input item at a time; invalid config gives one invalid item.
// Synchronous reset loads set_size 8, subset_size 3 and clears all entry
// valid bits, so every position j reads as j.
`timescale 1ns / 1ps

module combination_enumerator #(
  parameter int MAX_SET    = 64,
  parameter int MAX_SUBSET = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  cmbenum_in_if.sink                        in_ch,
  cmbenum_out_if.source                     out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [cmbenum_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [cmbenum_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [cmbenum_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int AW = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;
  localparam int CW = (AW + 1 > int'(cmbenum_pkg::SUB_W)) ? AW + 1
                                                           : int'(cmbenum_pkg::SUB_W);
  localparam int EW = cmbenum_pkg::ELEM_W;
  localparam int CMP_W = 9;

  // configuration
  logic [cmbenum_pkg::SET_W-1:0] set_size_r;
  logic [cmbenum_pkg::SUB_W-1:0] subset_size_r;
  logic                          cfg_wr;
  cmbenum_pkg::reg_idx_t         cfg_idx;

  // element store and valid bits
  logic [EW-1:0]         mem [MAX_SUBSET];
  logic [MAX_SUBSET-1:0] vld_r;
  logic [EW-1:0]         rdata_r;
  logic                  rvld_r;
  logic [AW-1:0]         rd_addr_r;

  logic          rd_en, mem_we, vld_clr;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  // control
  cmbenum_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic [CW-1:0] emit_idx_r, emit_idx_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic [EW-1:0] base_r, base_nxt;
  logic          wrapped_r, wrapped_nxt;
  logic          chk_v_r, chk_v_nxt;
  logic          s1_v_r, s1_v_nxt;
  logic          s1_mem_r, s1_mem_nxt;
  logic [CW-1:0] s1_pos_r, s1_pos_nxt;
  logic [EW-1:0] s1_val_r, s1_val_nxt;

  // output register
  logic                            out_valid_r;
  logic [cmbenum_pkg::POS_W-1:0]   out_pos_r;
  logic [EW-1:0]                   out_val_r;
  logic                            out_last_r, out_wrap_r, out_inv_r;

  logic          in_fire, out_free, s1_move, issue, out_load, out_inv;
  logic          cfg_bad, grow;
  logic [CW-1:0] k_cw;
  logic [EW-1:0] e_mem;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cmbenum_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r    <= cmbenum_pkg::SET_SIZE_RST;
      subset_size_r <= cmbenum_pkg::SUB_SIZE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cmbenum_pkg::REG_SET_SIZE: set_size_r    <= cfg_pwdata[cmbenum_pkg::SET_W-1:0];
        cmbenum_pkg::REG_SUB_SIZE: subset_size_r <= cfg_pwdata[cmbenum_pkg::SUB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      cmbenum_pkg::REG_SET_SIZE: cfg_prdata = cmbenum_pkg::DATA_W'(set_size_r);
      cmbenum_pkg::REG_SUB_SIZE: cfg_prdata = cmbenum_pkg::DATA_W'(subset_size_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- shared terms
  assign k_cw    = CW'(subset_size_r);
  assign cfg_bad = (subset_size_r == '0) || (32'(subset_size_r) > MAX_SUBSET) ||
                   (32'(set_size_r) > MAX_SET) ||
                   (cmbenum_pkg::SET_W'(subset_size_r) > set_size_r);

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_move  = s1_v_r && out_free;
  assign issue    = (emit_idx_r != k_cw) && (!s1_v_r || s1_move);

  // an entry never written since the last reload reads as its own index
  assign e_mem = rvld_r ? rdata_r : EW'(rd_addr_r);
  assign grow  = (CMP_W'(e_mem) + CMP_W'(subset_size_r)) <
                 (CMP_W'(set_size_r) + CMP_W'(rd_addr_r));

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cmbenum_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (cfg_bad)               state_nxt = cmbenum_pkg::ST_INV;
          else if (in_ch.restart)    state_nxt = cmbenum_pkg::ST_EMIT;
          else                       state_nxt = cmbenum_pkg::ST_SCAN;
        end
      end
      cmbenum_pkg::ST_SCAN: begin
        if (chk_v_r && (grow || rd_addr_r == '0)) state_nxt = cmbenum_pkg::ST_EMIT;
      end
      cmbenum_pkg::ST_EMIT: begin
        if (emit_idx_r == k_cw && (!s1_v_r || s1_move)) state_nxt = cmbenum_pkg::ST_IDLE;
      end
      cmbenum_pkg::ST_INV: begin
        if (out_free) state_nxt = cmbenum_pkg::ST_IDLE;
      end
      default: state_nxt = cmbenum_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath control
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = scan_idx_r[AW-1:0];
    mem_we       = 1'b0;
    wr_addr      = emit_idx_r[AW-1:0];
    wr_data      = base_r + EW'(emit_idx_r - p_r);
    vld_clr      = 1'b0;
    scan_idx_nxt = scan_idx_r;
    chk_v_nxt    = 1'b0;
    p_nxt        = p_r;
    base_nxt     = base_r;
    wrapped_nxt  = wrapped_r;
    emit_idx_nxt = emit_idx_r;
    s1_v_nxt     = s1_v_r;
    s1_mem_nxt   = s1_mem_r;
    s1_pos_nxt   = s1_pos_r;
    s1_val_nxt   = s1_val_r;
    out_load     = 1'b0;
    out_inv      = 1'b0;

    unique case (state_r)
      cmbenum_pkg::ST_IDLE: begin
        if (in_fire) begin
          wrapped_nxt  = 1'b0;
          emit_idx_nxt = '0;
          p_nxt        = k_cw;  // all positions read from the store
          if (!cfg_bad) begin
            if (in_ch.restart) vld_clr = 1'b1;
            else               scan_idx_nxt = k_cw - CW'(1);
          end
        end
      end
      cmbenum_pkg::ST_SCAN: begin
        // read one position per cycle, right to left; check the one read last cycle
        rd_en        = 1'b1;
        chk_v_nxt    = 1'b1;
        scan_idx_nxt = (scan_idx_r == '0) ? '0 : scan_idx_r - CW'(1);
        if (chk_v_r) begin
          if (grow) begin
            p_nxt     = CW'(rd_addr_r);
            base_nxt  = e_mem + EW'(1);
            chk_v_nxt = 1'b0;
          end else if (rd_addr_r == '0) begin
            vld_clr     = 1'b1;
            wrapped_nxt = 1'b1;
            p_nxt       = k_cw;
            chk_v_nxt   = 1'b0;
          end
        end
      end
      cmbenum_pkg::ST_EMIT: begin
        if (s1_move) begin
          s1_v_nxt = 1'b0;
          out_load = 1'b1;
        end
        if (issue) begin
          s1_v_nxt     = 1'b1;
          s1_pos_nxt   = emit_idx_r;
          emit_idx_nxt = emit_idx_r + CW'(1);
          if (emit_idx_r < p_r) begin
            rd_en      = 1'b1;
            rd_addr    = emit_idx_r[AW-1:0];
            s1_mem_nxt = 1'b1;
          end else begin
            // refill from the grown position on; written back when issued
            mem_we     = 1'b1;
            s1_mem_nxt = 1'b0;
            s1_val_nxt = wr_data;
          end
        end
      end
      cmbenum_pkg::ST_INV: begin
        if (out_free) begin
          out_load = 1'b1;
          out_inv  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- store
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rdata_r   <= mem[rd_addr];
      rvld_r    <= vld_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)       vld_r <= '0;
    else if (vld_clr) vld_r <= '0;
    else if (mem_we)  vld_r[wr_addr] <= 1'b1;
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cmbenum_pkg::ST_IDLE;
      chk_v_r     <= 1'b0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chk_v_r <= chk_v_nxt;
      s1_v_r  <= s1_v_nxt;
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    emit_idx_r <= emit_idx_nxt;
    p_r        <= p_nxt;
    base_r     <= base_nxt;
    wrapped_r  <= wrapped_nxt;
    s1_mem_r   <= s1_mem_nxt;
    s1_pos_r   <= s1_pos_nxt;
    s1_val_r   <= s1_val_nxt;
    if (out_load) begin
      if (out_inv) begin
        out_pos_r  <= '0;
        out_val_r  <= '0;
        out_last_r <= 1'b1;
        out_wrap_r <= 1'b0;
        out_inv_r  <= 1'b1;
      end else begin
        out_pos_r  <= cmbenum_pkg::POS_W'(s1_pos_r);
        out_val_r  <= s1_mem_r ? e_mem : s1_val_r;
        out_last_r <= (s1_pos_r + CW'(1)) == k_cw;
        out_wrap_r <= wrapped_r;
        out_inv_r  <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- ports
  assign in_ch.ready          = (state_r == cmbenum_pkg::ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.position      = out_pos_r;
  assign out_ch.element_value = out_val_r;
  assign out_ch.last_element  = out_last_r;
  assign out_ch.wrapped       = out_wrap_r;
  assign out_ch.invalid       = out_inv_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != cmbenum_pkg::ST_IDLE)
    else $error("item accepted but control stayed idle");

  a_refill_above_grow: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (emit_idx_r >= p_r && state_r == cmbenum_pkg::ST_EMIT))
    else $error("write-back below the grown position");

  a_read_data_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_mem_r) |-> state_r == cmbenum_pkg::ST_EMIT)
    else $error("pending store read outside emit phase");

  a_invalid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inv_r) |-> (out_last_r && !out_wrap_r))
    else $error("invalid result not marked last");
`endif

endmodule

### tb/sv/combination_enumerator_test.sv
// Self-checking bench for combination_enumerator: directed and random restart/advance
// items, register writes with read-back, random stalls on both channels.
// Depends on cmbenum_pkg, cmbenum_in_if, cmbenum_out_if and the RTL top.
`timescale 1ns / 1ps

module combination_enumerator_test;

  localparam int MAX_SET    = 64;
  localparam int MAX_SUBSET = 16;
  localparam int RANDOM_ITEMS = 245;

  localparam int POS_W  = cmbenum_pkg::POS_W;
  localparam int ELEM_W = cmbenum_pkg::ELEM_W;
  localparam int SET_W  = cmbenum_pkg::SET_W;
  localparam int SUB_W  = cmbenum_pkg::SUB_W;
  localparam int ADDR_W = cmbenum_pkg::ADDR_W;
  localparam int DATA_W = cmbenum_pkg::DATA_W;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [ELEM_W-1:0] element_value;
    logic              last_element;
    logic              wrapped;
    logic              invalid;
  } element_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  cmbenum_in_if  in_if ();
  cmbenum_out_if out_if ();

  combination_enumerator #(
    .MAX_SET    (MAX_SET),
    .MAX_SUBSET (MAX_SUBSET)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow of the block: registers and the stored combination
  logic [SET_W-1:0]  set_size_q;
  logic [SUB_W-1:0]  subset_size_q;
  logic [ELEM_W-1:0] combo_list [MAX_SUBSET];
  element_t          due_elements [$];
  element_t          due_elem;

  int fail_count = 0;
  int ready_hold = 0;
  bit stall_on   = 1'b1;
  bit gap_on     = 1'b1;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void load_first_combo();
    for (int j = 0; j < MAX_SUBSET; j++) combo_list[j] = ELEM_W'(j);
  endfunction

  // Works out the elements one item produces and queues them.
  function automatic void next_combination(input bit restart);
    int unsigned m;
    int unsigned k;
    int unsigned base;
    bit          wrap;
    bit          grown;
    element_t    e;
    m     = set_size_q;
    k     = subset_size_q;
    wrap  = 1'b0;
    grown = 1'b0;
    if (k == 0 || k > MAX_SUBSET || m > MAX_SET || k > m) begin
      e.position      = '0;
      e.element_value = '0;
      e.last_element  = 1'b1;
      e.wrapped       = 1'b0;
      e.invalid       = 1'b1;
      due_elements.push_back(e);
      return;
    end
    if (restart) begin
      load_first_combo();
    end else begin
      // rightmost position that can still grow; stale values taken as stored
      for (int p = int'(k) - 1; p >= 0 && !grown; p--) begin
        if (combo_list[p] + k < m + p) begin
          base = combo_list[p] + 1;
          for (int j = p; j < int'(k); j++) combo_list[j] = ELEM_W'(base + j - p);
          grown = 1'b1;
        end
      end
      if (!grown) begin
        load_first_combo();
        wrap = 1'b1;
      end
    end
    for (int j = 0; j < int'(k); j++) begin
      e.position      = POS_W'(j);
      e.element_value = combo_list[j];
      e.last_element  = (j == int'(k) - 1);
      e.wrapped       = wrap;
      e.invalid       = 1'b0;
      due_elements.push_back(e);
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // results checked and items predicted at the same edge, in a fixed order
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (due_elements.size() == 0) begin
          $error("unexpected item: position %0d element_value %0d invalid %0b",
                 out_if.position, out_if.element_value, out_if.invalid);
          fail_count++;
        end else begin
          due_elem = due_elements.pop_front();
          check_field("position", due_elem.position, out_if.position);
          check_field("element_value", due_elem.element_value, out_if.element_value);
          check_field("last_element", due_elem.last_element, out_if.last_element);
          check_field("wrapped", due_elem.wrapped, out_if.wrapped);
          check_field("invalid", due_elem.invalid, out_if.invalid);
        end
      end
      if (in_if.valid && in_if.ready) next_combination(in_if.restart);
    end
  end

  // result side back-pressure: fresh stall drawn after each accepted item
  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) ready_hold = stall_on ? $urandom_range(0, 4) : 0;
    else if (ready_hold > 0) ready_hold--;
    out_if.ready <= (ready_hold == 0);
  end

  task automatic send_item(input bit restart);
    int gap;
    gap = gap_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.restart <= restart;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (due_elements.size() != 0);
  endtask

  task automatic cfg_read(input cmbenum_pkg::reg_idx_t idx,
                          input logic [DATA_W-1:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_W'(int'(idx) * 4);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $error("%s: expected %0d, got %0d", idx.name(), want, cfg_prdata);
      fail_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // write with junk in the unused upper bits, then read back
  task automatic cfg_write(input cmbenum_pkg::reg_idx_t idx, input int unsigned value);
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] kept;
    mask = (idx == cmbenum_pkg::REG_SET_SIZE) ? DATA_W'((1 << SET_W) - 1)
                                              : DATA_W'((1 << SUB_W) - 1);
    kept = DATA_W'(value) & mask;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(int'(idx) * 4);
    cfg_pwdata  <= (DATA_W'($urandom()) & ~mask) | kept;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == cmbenum_pkg::REG_SET_SIZE) set_size_q = kept[SET_W-1:0];
    else subset_size_q = kept[SUB_W-1:0];
    cfg_read(idx, kept);
  endtask

  task automatic configure(input int unsigned m, input int unsigned k);
    wait_idle();
    cfg_write(cmbenum_pkg::REG_SET_SIZE, m);
    cfg_write(cmbenum_pkg::REG_SUB_SIZE, k);
  endtask

  task automatic test_reset_state();
    cfg_read(cmbenum_pkg::REG_SET_SIZE, DATA_W'(cmbenum_pkg::SET_SIZE_RST));
    cfg_read(cmbenum_pkg::REG_SUB_SIZE, DATA_W'(cmbenum_pkg::SUB_SIZE_RST));
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  task automatic test_final_combination();
    configure(4, 3);
    send_item(1'b1);
    repeat (4) send_item(1'b0);
    // single combination: every advance wraps
    configure(1, 1);
    repeat (2) send_item(1'b0);
  endtask

  task automatic test_unusable_config();
    configure(8, 0);
    send_item(1'b0);
    configure(8, 17);
    send_item(1'b1);
    configure(65, 3);
    send_item(1'b0);
    configure(127, 31);
    send_item(1'b0);
    configure(2, 3);
    send_item(1'b1);
    configure(4, 3);
    send_item(1'b0);
  endtask

  task automatic test_widest();
    configure(MAX_SET, MAX_SUBSET);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
  endtask

  task automatic test_stale_list();
    configure(3, 2);
    send_item(1'b0);
    configure(MAX_SET, MAX_SUBSET);
    send_item(1'b0);
  endtask

  task automatic test_random_walk();
    int          sent;
    int          run_len;
    int unsigned m;
    int unsigned k;
    bit          bad;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0: begin m = $urandom_range(1, 64);   k = 0;                       end
            1: begin m = $urandom_range(1, 64);   k = $urandom_range(17, 31);  end
            2: begin m = $urandom_range(65, 127); k = $urandom_range(1, 16);   end
            default: begin m = $urandom_range(0, 15); k = $urandom_range(m + 1, 16); end
          endcase
        end
        1: begin m = $urandom_range(17, 64); k = $urandom_range(1, 16); end
        default: begin m = $urandom_range(1, 10); k = $urandom_range(1, m); end
      endcase
      bad = (k == 0 || k > MAX_SUBSET || m > MAX_SET || k > m);
      configure(m, k);
      stall_on = ($urandom_range(0, 3) != 0);
      gap_on   = ($urandom_range(0, 3) != 0);
      run_len  = bad ? $urandom_range(1, 3) : $urandom_range(4, 24);
      // sometimes carry on from the old list rather than restarting
      if ($urandom_range(0, 2) == 0) begin
        send_item(1'b1);
        sent++;
      end
      repeat (run_len) begin
        send_item($urandom_range(0, 9) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.restart = 1'b0;
    out_if.ready  = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    set_size_q    = cmbenum_pkg::SET_SIZE_RST;
    subset_size_q = cmbenum_pkg::SUB_SIZE_RST;
    load_first_combo();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_final_combination();
    test_unusable_config();
    test_widest();
    test_stale_list();
    test_random_walk();

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
